// ===== hdl/bitmap_slot_allocator_assert.svh =====
// assertion macros for the slot allocator rtl
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bsa_pkg.sv =====
// shared widths and constants for the slot allocator
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int WordBits = 32;
  localparam int BitW     = 5;
  localparam int SlotW    = 17;
  localparam int BaseW    = 16;

  localparam logic [WordBits-1:0] MaskHalf   = 32'h0000_FFFF;
  localparam logic [WordBits-1:0] MaskByte   = 32'h0000_00FF;
  localparam logic [WordBits-1:0] MaskNibble = 32'h0000_000F;
  localparam logic [WordBits-1:0] MaskPair   = 32'h0000_0003;
  localparam logic [WordBits-1:0] MaskBit    = 32'h0000_0001;
  localparam logic [WordBits-1:0] WordAllOne = 32'hFFFF_FFFF;

endpackage

// ===== hdl/bsa_map.sv =====
// free map storage: one word per read, one word per write, per-word valid bits
`timescale 1ns / 1ps

module bsa_map #(
  parameter int MAP_WORDS = 8,
  parameter int ADDR_W    = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [ADDR_W-1:0]             rd_addr_i,
  output logic [bsa_pkg::WordBits-1:0]  rd_word_o,
  input  logic                          wr_en_i,
  input  logic [ADDR_W-1:0]             wr_addr_i,
  input  logic [bsa_pkg::WordBits-1:0]  wr_word_i
);
  import bsa_pkg::*;

  logic [WordBits-1:0]  mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid_q;
  logic [WordBits-1:0]  rd_data_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_word_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // a word never written reads as all ones: all slots free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_word_o = rd_valid_q ? rd_data_q : WordAllOne;

endmodule

// ===== hdl/bsa_unit.sv =====
// shared datapath: lowest set bit finder and one add/subtract
`timescale 1ns / 1ps

module bsa_unit (
  input  logic [bsa_pkg::WordBits-1:0] word_i,
  input  logic [bsa_pkg::SlotW-1:0]    add_a_i,
  input  logic [bsa_pkg::SlotW-1:0]    add_b_i,
  input  logic                         sub_i,
  output logic                         nonzero_o,
  output logic [bsa_pkg::BitW-1:0]     lsb_o,
  output logic [bsa_pkg::SlotW:0]      sum_o
);
  import bsa_pkg::*;

  function automatic logic [BitW-1:0] lowest_set(input logic [WordBits-1:0] w);
    logic [WordBits-1:0] x;
    logic [BitW-1:0]     c;
    x = w;
    c = '0;
    if ((x & MaskHalf) == '0) begin
      c[4] = 1'b1;
      x    = x >> 16;
    end
    if ((x & MaskByte) == '0) begin
      c[3] = 1'b1;
      x    = x >> 8;
    end
    if ((x & MaskNibble) == '0) begin
      c[2] = 1'b1;
      x    = x >> 4;
    end
    if ((x & MaskPair) == '0) begin
      c[1] = 1'b1;
      x    = x >> 2;
    end
    if ((x & MaskBit) == '0) begin
      c[0] = 1'b1;
    end
    return c;
  endfunction

  logic [SlotW:0] b_ext;

  assign nonzero_o = (word_i != '0);
  assign lsb_o     = lowest_set(word_i);

  // subtract as add of the inverted operand; bit 17 set means a borrow
  assign b_ext = sub_i ? ~{1'b0, add_b_i} : {1'b0, add_b_i};
  assign sum_o = {1'b0, add_a_i} + b_ext + {{SlotW{1'b0}}, sub_i};

endmodule

// ===== hdl/bitmap_slot_allocator.sv =====
// top level: sequencer, config register and result registers of the slot allocator
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_assert.svh"

// Bitmap slot allocator. A request is taken when start is high and busy is low;
// func_i = 0 allocates the lowest free slot of the first non-empty map word,
// func_i = 1 releases free_slot_i. Exactly one result comes back per request,
// shown for a single cycle with done_o high; the receiver cannot hold it off.
// The map is read one 32-bit word per cycle through a single read port. An
// allocate scans words from word 0 until one has a free slot or the last word
// is read. A release checks the slot against base and the map size, then reads,
// modifies and writes back its word, or ends after the check when out of range.
// No clearing pass follows reset. base_index sits at byte address 0; the user
// must write it only while the block is idle, which the block does not enforce.
module bitmap_slot_allocator #(
  parameter int SLOT_COUNT = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request side
  input  logic                      start,
  output logic                      busy,
  input  logic                      func_i,
  input  logic [bsa_pkg::SlotW-1:0] free_slot_i,
  // result side
  output logic                      done_o,
  output logic [bsa_pkg::SlotW-1:0] slot_index_o,
  output logic                      found_o,
  output logic                      out_of_range_o,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import bsa_pkg::*;

  localparam int MapWords = (SLOT_COUNT + WordBits - 1) / WordBits;
  localparam int MapBits  = MapWords * WordBits;
  localparam int AddrW    = (MapWords > 1) ? $clog2(MapWords) : 1;
  localparam int OffW     = AddrW + BitW;

  localparam logic [SlotW-1:0] MapBitsLim = SlotW'(MapBits);
  localparam logic [AddrW-1:0] LastWord   = AddrW'(MapWords - 1);

  localparam logic FuncAlloc  = 1'b0;
  localparam logic RegBaseIdx = 1'b0;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FCHK = 2'd2;
  localparam logic [1:0] S_FWR  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [AddrW-1:0]    scan_q, scan_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [OffW-1:0]     off_q, off_d;
  logic [BaseW-1:0]    base_q;

  logic                done_q, done_d;
  logic [SlotW-1:0]    res_slot_q, res_slot_d;
  logic                res_found_q, res_found_d;
  logic                res_oor_q, res_oor_d;

  logic                rd_en, wr_en;
  logic [AddrW-1:0]    rd_addr, wr_addr;
  logic [WordBits-1:0] map_word, wr_word;

  logic [SlotW-1:0]    add_a, add_b;
  logic                add_sub;
  logic                word_nonzero;
  logic [BitW-1:0]     word_lsb;
  logic [SlotW:0]      sum;

  logic                accept;
  logic                cfg_wr;

  bsa_map #(
    .MAP_WORDS (MapWords),
    .ADDR_W    (AddrW)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_word_o (map_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_word_i (wr_word)
  );

  bsa_unit u_unit (
    .word_i    (map_word),
    .add_a_i   (add_a),
    .add_b_i   (add_b),
    .sub_i     (add_sub),
    .nonzero_o (word_nonzero),
    .lsb_o     (word_lsb),
    .sum_o     (sum)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // the adder offsets a release by base, or adds base to a granted position
  always_comb begin
    if (state_q == S_FCHK) begin
      add_a   = slot_q;
      add_b   = {1'b0, base_q};
      add_sub = 1'b1;
    end else begin
      add_a   = {1'b0, base_q};
      add_b   = SlotW'({scan_q, word_lsb});
      add_sub = 1'b0;
    end
  end

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    slot_d      = slot_q;
    off_d       = off_q;
    done_d      = 1'b0;
    res_slot_d  = '0;
    res_found_d = 1'b0;
    res_oor_d   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = scan_q;
    wr_en       = 1'b0;
    wr_addr     = scan_q;
    wr_word     = map_word;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          slot_d = free_slot_i;
          if (func_i == FuncAlloc) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            scan_d  = '0;
            state_d = S_SCAN;
          end else begin
            state_d = S_FCHK;
          end
        end
      end
      S_SCAN: begin
        if (word_nonzero) begin
          wr_en       = 1'b1;
          wr_addr     = scan_q;
          wr_word     = map_word & ~(WordBits'(1) << word_lsb);
          done_d      = 1'b1;
          res_slot_d  = sum[SlotW-1:0];
          res_found_d = 1'b1;
          state_d     = S_IDLE;
        end else if (scan_q == LastWord) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          scan_d  = scan_q + AddrW'(1);
          rd_en   = 1'b1;
          rd_addr = scan_q + AddrW'(1);
        end
      end
      S_FCHK: begin
        // borrow means below base; otherwise compare against the map size
        if (sum[SlotW] || (sum[SlotW-1:0] >= MapBitsLim)) begin
          done_d    = 1'b1;
          res_oor_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          off_d   = sum[OffW-1:0];
          rd_en   = 1'b1;
          rd_addr = sum[OffW-1:BitW];
          state_d = S_FWR;
        end
      end
      S_FWR: begin
        wr_en   = 1'b1;
        wr_addr = off_q[OffW-1:BitW];
        wr_word = map_word | (WordBits'(1) << off_q[BitW-1:0]);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    off_q  <= off_d;
    if (done_d) begin
      res_slot_q  <= res_slot_d;
      res_found_q <= res_found_d;
      res_oor_q   <= res_oor_d;
    end
  end

  // configuration register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_wr && (paddr[2] == RegBaseIdx)) begin
      base_q <= pwdata[BaseW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegBaseIdx) ? {{(32 - BaseW){1'b0}}, base_q} : '0;

  assign done_o         = done_q;
  assign slot_index_o   = res_slot_q;
  assign found_o        = res_found_q;
  assign out_of_range_o = res_oor_q;

  `BSA_ASSERT_NOW(a_flags_exclusive, done_o, !(found_o && out_of_range_o), "found with range error")
  `BSA_ASSERT_NOW(a_miss_zero_slot, done_o && !found_o, slot_index_o == '0, "slot without grant")
  `BSA_ASSERT_NEXT(a_accept_busy, accept, busy, "request did not start work")
  `BSA_ASSERT_NEXT(a_hit_grants, (state_q == S_SCAN) && word_nonzero, done_o && found_o, "hit not granted")
  `BSA_ASSERT_NOW(a_end_result, $fell(busy), done_o, "work ended without result")

endmodule
